// ===== src/swpr_pkg.sv =====
// swpr_pkg: shared types, constants and step helpers for the swappiness regulator
// no dependencies
`timescale 1ns / 1ps

package swpr_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_STOP,
    OP_START
  } op_t;

  typedef enum logic [1:0] {
    PER_CRIT,
    PER_RESTR,
    PER_NORM
  } period_t;

  localparam logic [7:0] REG_STALL_LIMIT      = 8'd0;
  localparam logic [7:0] REG_CRIT_STALL_LIMIT = 8'd1;

  localparam logic [6:0]  SWP_MAX     = 7'd100;
  localparam logic [7:0]  STALL_SAT   = 8'd255;
  localparam logic [7:0]  STALL_RST   = 8'd128;
  localparam logic [7:0]  CRIT_RST    = 8'd8;
  localparam logic [17:0] T_CRIT      = 18'd8000;
  localparam logic [17:0] T_RESTR     = 18'd16000;
  localparam logic [17:0] T_NORM      = 18'd32000;

  typedef struct packed {
    op_t         op;
    logic [31:0] total_kb;
    logic [31:0] free_kb;
    logic [7:0]  swp_in;
    logic        display_on;
  } item_t;

  typedef struct packed {
    logic [6:0]  new_swappiness;
    logic        write_swappiness;
    logic        scheduled;
    logic [17:0] wait_ms;
  } result_t;

  typedef struct packed {
    logic [31:0] previous_free;
    logic        first_sample;
    logic [7:0]  stall_count;
    period_t     period_sel;
    logic        running;
  } state_t;

  typedef struct packed {
    logic       wr;
    logic [6:0] val;
  } nudge_t;

  // move swappiness by a signed step, clamped to 0..100
  function automatic nudge_t nudge(input logic [6:0] cur, input logic signed [5:0] step);
    logic signed [8:0] lvl;
    nudge_t            r;
    r.wr  = 1'b0;
    r.val = cur;
    lvl   = $signed({2'b00, cur}) + $signed({{3{step[5]}}, step});
    if (!((cur >= SWP_MAX && !step[5]) || (cur == 7'd0 && (step[5] || step == 6'sd0)))) begin
      r.wr = 1'b1;
      if (lvl < 9'sd0) begin
        r.val = 7'd0;
      end else if (lvl > $signed({2'b00, SWP_MAX})) begin
        r.val = SWP_MAX;
      end else begin
        r.val = lvl[6:0];
      end
    end
    return r;
  endfunction

  function automatic logic [17:0] period_ms(input period_t sel);
    logic [17:0] p;
    case (sel)
      PER_CRIT:  p = T_CRIT;
      PER_RESTR: p = T_RESTR;
      default:   p = T_NORM;
    endcase
    return p;
  endfunction

endpackage

// ===== src/swap_pressure_swappiness_regulator.sv =====
// swap_pressure_swappiness_regulator: top level, input and result registers, state, config
// depends on swpr_pkg and swpr_eval
//
// channel | dir | accepted when          | content
// s_*     | in  | s_tvalid & s_tready    | one swap sample or stop/start op
// m_*     | out | m_tvalid & m_tready    | one result per input item
// cfg_*   | in  | cfg_valid & cfg_ready  | register write, index 0 or 1
//
// one item per cycle sustained while m_tready is high; items pass the input register, then the result register
// state is updated at the edge where an item moves from the input to the result register
// a stalled result holds while the input register can still take one more item
// rst is synchronous and clears control state and config to reset values
`timescale 1ns / 1ps

module swap_pressure_swappiness_regulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // total_kb, free_kb, swp_in, display_on, zero pad to 80
  input  logic [79:0] s_tdata,
  // op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // new_swappiness, write_swappiness, scheduled, wait_ms, zero pad to 32
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import swpr_pkg::*;

  logic       in_valid;
  item_t      in_item;
  state_t     state, state_next;
  result_t    res_next, res;
  logic [7:0] stall_limit, critical_stall_limit;
  logic       advance;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op         <= op_t'(s_tuser);
      in_item.total_kb   <= s_tdata[31:0];
      in_item.free_kb    <= s_tdata[63:32];
      in_item.swp_in     <= s_tdata[71:64];
      in_item.display_on <= s_tdata[72];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_limit          <= STALL_RST;
      critical_stall_limit <= CRIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STALL_LIMIT) begin
        stall_limit <= cfg_data;
      end else if (cfg_index == REG_CRIT_STALL_LIMIT) begin
        critical_stall_limit <= cfg_data;
      end
    end
  end

  swpr_eval u_eval (
    .item                 (in_item),
    .state                (state),
    .stall_limit          (stall_limit),
    .critical_stall_limit (critical_stall_limit),
    .result               (res_next),
    .state_next           (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.previous_free <= 32'd0;
      state.first_sample  <= 1'b1;
      state.stall_count   <= 8'd0;
      state.period_sel    <= PER_CRIT;
      state.running       <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {5'd0, res.wait_ms, res.scheduled, res.write_swappiness,
                    res.new_swappiness};

endmodule

// ===== src/swpr_eval.sv =====
// swpr_eval: single-pass evaluation of one item against the regulator state
// depends on swpr_pkg
`timescale 1ns / 1ps

module swpr_eval (
  input  swpr_pkg::item_t   item,
  input  swpr_pkg::state_t  state,
  input  logic [7:0]        stall_limit,
  input  logic [7:0]        critical_stall_limit,
  output swpr_pkg::result_t result,
  output swpr_pkg::state_t  state_next
);
  import swpr_pkg::*;

  logic [6:0]        cur;
  logic [31:0]       t4, t8, t16, t32, t64;
  logic [31:0]       mag;
  logic              dec, same;
  logic [7:0]        stall_inc;
  logic              zone_has;
  logic signed [5:0] zone_step;
  logic              late_has;
  logic signed [5:0] late_step;
  nudge_t            n_zone, n_late, n_sel;
  logic              wr;
  logic [6:0]        val;
  logic              sch;
  logic [17:0]       wait_v;

  assign cur = (item.swp_in > {1'b0, SWP_MAX}) ? SWP_MAX
                                              : item.swp_in[6:0];
  assign t4  = item.total_kb >> 2;
  assign t8  = item.total_kb >> 3;
  assign t16 = item.total_kb >> 4;
  assign t32 = item.total_kb >> 5;
  assign t64 = item.total_kb >> 6;

  // exact magnitude and direction of the free-swap change
  assign dec  = state.previous_free > item.free_kb;
  assign same = state.previous_free == item.free_kb;
  assign mag  = dec ? (state.previous_free - item.free_kb)
                    : (item.free_kb - state.previous_free);

  assign stall_inc = (state.stall_count < STALL_SAT) ? state.stall_count + 8'd1
                                                     : state.stall_count;

  assign n_zone = nudge(cur, zone_step);
  assign n_late = nudge(cur, late_step);

  always_comb begin
    state_next = state;
    wr         = 1'b0;
    val        = 7'd0;
    sch        = 1'b0;
    wait_v     = 18'd0;
    zone_has   = 1'b0;
    zone_step  = 6'sd0;
    late_has   = 1'b0;
    late_step  = 6'sd0;
    n_sel      = '0;
    case (item.op)
      OP_STOP: begin
        if (state.running) begin
          wr                      = 1'b1;
          val                     = SWP_MAX;
          state_next.first_sample = 1'b1;
          state_next.running      = 1'b0;
        end
      end
      OP_START: begin
        if (!state.running) begin
          state_next.running = 1'b1;
          sch                = 1'b1;
          wait_v             = T_CRIT;
        end
      end
      OP_SAMPLE: begin
        if (state.running && item.total_kb != 32'd0) begin
          if (state.first_sample) begin
            state_next.first_sample = 1'b0;
          end else begin
            state_next.stall_count = stall_inc;
            if (item.free_kb >= t4) begin
              // normal zone
              if (cur != SWP_MAX) begin
                wr  = 1'b1;
                val = SWP_MAX;
              end
              state_next.period_sel  = PER_NORM;
              state_next.stall_count = 8'd0;
            end else if (item.free_kb <= t16) begin
              // critical zone
              if (same) begin
                zone_has  = stall_inc > critical_stall_limit;
                zone_step = -6'sd4;
              end else if (dec) begin
                zone_has  = 1'b1;
                zone_step = (mag > t32) ? -6'sd16 : (mag > t64) ? -6'sd8 : -6'sd4;
              end
              state_next.period_sel = PER_CRIT;
            end else if (item.free_kb < t8) begin
              // restricted zone
              zone_has = mag > t64;
              if (mag > t16) begin
                zone_step = 6'sd4;
              end else if (mag > t32) begin
                zone_step = 6'sd2;
              end else begin
                zone_step = 6'sd1;
              end
              if (dec || same) begin
                zone_step = -zone_step;
              end
              late_has  = stall_inc > stall_limit;
              late_step = 6'sd1;
              state_next.period_sel = PER_RESTR;
            end else begin
              // middle zone
              zone_has  = mag > t32;
              zone_step = (mag > t16) ? 6'sd2 : 6'sd1;
              if (dec || same) begin
                zone_step = -zone_step;
              end
              late_has  = stall_inc > stall_limit;
              late_step = 6'sd2;
              state_next.period_sel = PER_NORM;
            end
            if (zone_has && n_zone.wr) begin
              n_sel = n_zone;
            end
            if (late_has && n_late.wr) begin
              n_sel = n_late;
            end
            if (n_sel.wr) begin
              wr  = 1'b1;
              val = n_sel.val;
            end
          end
          state_next.previous_free = item.free_kb;
          sch    = 1'b1;
          wait_v = item.display_on ? period_ms(state_next.period_sel)
                                   : period_ms(state_next.period_sel) << 3;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.new_swappiness   = wr ? val : 7'd0;
  assign result.write_swappiness = wr;
  assign result.scheduled        = sch;
  assign result.wait_ms          = wait_v;

endmodule

// ===== src/swpr_checker.sv =====
// swpr_checker: port-level assertions for the swappiness regulator, bound to the top level
// depends on swap_pressure_swappiness_regulator ports only
`timescale 1ns / 1ps

module swpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // no result may appear right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an item accepted while no result is valid passes the input and result registers and then shows up
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> ##1 m_tvalid)
    else $error("accepted item did not reach the output");

  // swappiness stays in range and is zero without a write
  a_swp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] <= 7'd100) && (m_tdata[7] || m_tdata[6:0] == 7'd0))
    else $error("bad swappiness field");

  // wait is zero when not scheduled, else one of the known periods
  a_wait_values: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[8] && m_tdata[26:9] == 18'd0) ||
                 (m_tdata[8] && (m_tdata[26:9] == 18'd8000 || m_tdata[26:9] == 18'd16000 ||
                  m_tdata[26:9] == 18'd32000 || m_tdata[26:9] == 18'd64000 ||
                  m_tdata[26:9] == 18'd128000 || m_tdata[26:9] == 18'd256000)))
    else $error("bad wait field");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind swap_pressure_swappiness_regulator swpr_checker u_swpr_checker (.*);

// ===== tb/swpr_result_checker.sv =====
// swpr_result_checker: watches the sample, result and register channels of the regulator,
// predicts each result from its own copy of the regulator state and compares field by field
// depends on swpr_pkg
`timescale 1ns / 1ps

module swpr_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);
  import swpr_pkg::*;

  logic [31:0] last_free;
  bit          awaiting_first;
  logic [7:0]  idle_samples;
  period_t     period;
  bit          enabled;
  logic [7:0]  stall_lim;
  logic [7:0]  crit_lim;

  result_t expected_results[$];
  int      mismatch_count = 0;

  task automatic flag(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void step_level(input int unsigned lvl, input int delta, inout bit wr,
                                     inout logic [6:0] val);
    int tgt;
    if ((lvl >= SWP_MAX && delta >= 0) || (lvl == 0 && delta <= 0)) return;
    tgt = int'(lvl) + delta;
    if (tgt < 0) tgt = 0;
    if (tgt > int'(SWP_MAX)) tgt = int'(SWP_MAX);
    wr  = 1'b1;
    val = tgt[6:0];
  endfunction

  function automatic result_t regulate(input logic [1:0] op, input logic [31:0] total,
                                       input logic [31:0] fr, input logic [7:0] cur_in,
                                       input logic disp);
    result_t     r;
    bit          wr;
    bit          sch;
    logic [6:0]  val;
    logic [17:0] per_ms;
    logic [17:0] delay_ms;
    int unsigned lvl;
    longint      drop;
    longint      rise;
    longint      q16;
    longint      q32;
    longint      q64;
    wr       = 1'b0;
    sch      = 1'b0;
    val      = '0;
    delay_ms = '0;
    lvl      = 32'((cur_in > 8'(SWP_MAX)) ? 8'(SWP_MAX) : cur_in);
    q16      = longint'(total >> 4);
    q32      = longint'(total >> 5);
    q64      = longint'(total >> 6);
    drop     = $signed({32'd0, last_free}) - $signed({32'd0, fr});
    rise     = -drop;
    case (op)
      OP_STOP: begin
        if (enabled) begin
          wr             = 1'b1;
          val            = SWP_MAX;
          awaiting_first = 1'b1;
          enabled        = 1'b0;
        end
      end
      OP_START: begin
        if (!enabled) begin
          enabled  = 1'b1;
          sch      = 1'b1;
          delay_ms = T_CRIT;
        end
      end
      OP_SAMPLE: begin
        if (enabled && total != 0) begin
          if (awaiting_first) begin
            awaiting_first = 1'b0;
          end else begin
            if (idle_samples != STALL_SAT) idle_samples++;
            if (fr >= (total >> 2)) begin
              if (lvl != SWP_MAX) begin
                wr  = 1'b1;
                val = SWP_MAX;
              end
              period       = PER_NORM;
              idle_samples = '0;
            end else if (fr <= (total >> 4)) begin
              if (drop == 0) begin
                if (idle_samples > crit_lim) step_level(lvl, -4, wr, val);
              end else if (drop > 0) begin
                if (drop > q32) step_level(lvl, -16, wr, val);
                else if (drop > q64) step_level(lvl, -8, wr, val);
                else step_level(lvl, -4, wr, val);
              end
              period = PER_CRIT;
            end else if (fr < (total >> 3)) begin
              if (drop >= 0) begin
                if (drop > q16) step_level(lvl, -4, wr, val);
                else if (drop > q32) step_level(lvl, -2, wr, val);
                else if (drop > q64) step_level(lvl, -1, wr, val);
              end else begin
                if (rise > q16) step_level(lvl, 4, wr, val);
                else if (rise > q32) step_level(lvl, 2, wr, val);
                else if (rise > q64) step_level(lvl, 1, wr, val);
              end
              if (idle_samples > stall_lim) step_level(lvl, 1, wr, val);
              period = PER_RESTR;
            end else begin
              if (drop >= 0) begin
                if (drop > q16) step_level(lvl, -2, wr, val);
                else if (drop > q32) step_level(lvl, -1, wr, val);
              end else begin
                if (rise > q16) step_level(lvl, 2, wr, val);
                else if (rise > q32) step_level(lvl, 1, wr, val);
              end
              if (idle_samples > stall_lim) step_level(lvl, 2, wr, val);
              period = PER_NORM;
            end
          end
          last_free = fr;
          sch       = 1'b1;
          per_ms    = (period == PER_CRIT) ? T_CRIT : (period == PER_RESTR) ? T_RESTR : T_NORM;
          delay_ms  = disp ? per_ms : (per_ms << 3);
        end
      end
      default: ;
    endcase
    r.new_swappiness   = wr ? val : 7'd0;
    r.write_swappiness = wr;
    r.scheduled        = sch;
    r.wait_ms          = sch ? delay_ms : 18'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      last_free      = '0;
      awaiting_first = 1'b1;
      idle_samples   = '0;
      period         = PER_CRIT;
      enabled        = 1'b1;
      stall_lim      = STALL_RST;
      crit_lim       = CRIT_RST;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STALL_LIMIT:      stall_lim = cfg_data;
          REG_CRIT_STALL_LIMIT: crit_lim  = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.new_swappiness   = m_tdata[6:0];
        got.write_swappiness = m_tdata[7];
        got.scheduled        = m_tdata[8];
        got.wait_ms          = m_tdata[26:9];
        if (expected_results.size() == 0) begin
          flag($sformatf("result %h with no item outstanding", m_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.new_swappiness !== want.new_swappiness)
            flag($sformatf("new_swappiness %0d, expected %0d",
                           got.new_swappiness, want.new_swappiness));
          if (got.write_swappiness !== want.write_swappiness)
            flag($sformatf("write_swappiness %b, expected %b",
                           got.write_swappiness, want.write_swappiness));
          if (got.scheduled !== want.scheduled)
            flag($sformatf("scheduled %b, expected %b", got.scheduled, want.scheduled));
          if (got.wait_ms !== want.wait_ms)
            flag($sformatf("wait_ms %0d, expected %0d", got.wait_ms, want.wait_ms));
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(regulate(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                            s_tdata[71:64], s_tdata[72]));
    end
    errors  <= mismatch_count;
    pending <= expected_results.size();
  end

endmodule

// ===== tb/tb_swap_pressure_swappiness_regulator.sv =====
// tb_swap_pressure_swappiness_regulator: drives samples, stop/start ops and limit writes
// into the regulator with random gaps on both sides and gives the verdict
// depends on swpr_pkg, swpr_result_checker and the regulator rtl
`timescale 1ns / 1ps

module tb_swap_pressure_swappiness_regulator;
  import swpr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         WATCHDOG  = 2000;
  localparam longint     FREE_MAX  = 64'h0000_0000_FFFF_FFFF;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  int errors;
  int pending;
  bit idle_on = 1'b1;
  int rx_hold = 0;
  int rx_gap;
  int quiet_cycles = 0;

  swap_pressure_swappiness_regulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  swpr_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      rx_gap = idle_len();
      if (rx_gap > 0) begin
        rx_hold  <= rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [31:0] total,
                           input logic [31:0] fr, input logic [7:0] cur, input logic disp);
    int gap;
    s_tuser  <= op;
    s_tdata  <= {7'd0, disp, cur, fr, total};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic sample(input logic [31:0] total, input logic [31:0] fr, input logic [7:0] cur,
                        input logic disp);
    push_item(OP_SAMPLE, total, fr, cur, disp);
  endtask

  // holds the sender until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input logic [7:0] stall, input logic [7:0] crit);
    cfg_index <= REG_STALL_LIMIT;
    cfg_data  <= stall;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_CRIT_STALL_LIMIT;
    cfg_data  <= crit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_cur();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd100;
    if (r == 2) return 8'($urandom_range(101, 255));
    return 8'($urandom_range(0, 100));
  endfunction

  function automatic logic [31:0] pick_total();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom | 32'h0100_0000;
    if (r < 15) return $urandom_range(1, 300);
    if (r < 17) return 32'hFFFF_FFFF;
    return $urandom | 32'h1;
  endfunction

  function automatic logic [31:0] zone_free(input logic [31:0] total);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, total >> 4);
      1:       return $urandom_range(total >> 4, total >> 3);
      2:       return $urandom_range(total >> 3, total >> 2);
      default: return $urandom_range(total >> 2, total);
    endcase
  endfunction

  // start (or restart after a stop), then a run of samples drifting in and between zones
  task automatic run_walk(input int len, input bit no_normal);
    logic [31:0] total;
    logic [31:0] fr;
    logic [31:0] u16;
    longint      mag;
    longint      nxt;
    total = no_normal ? ($urandom | 32'h4000_0000) : pick_total();
    push_item(OP_START, $urandom, $urandom, pick_cur(), 1'($urandom_range(0, 1)));
    fr  = zone_free(total);
    u16 = total >> 4;
    for (int k = 0; k < len; k++) begin
      sample(total, fr, pick_cur(), 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 9))
        0, 1:    mag = '0;
        2, 3:    mag = longint'($urandom_range(0, u16 >> 2));
        4:       mag = longint'($urandom_range(u16 >> 2, u16 >> 1));
        5:       mag = longint'($urandom_range(u16 >> 1, u16));
        6:       mag = longint'(u16) + longint'($urandom_range(0, u16));
        7:       mag = longint'($urandom);
        default: mag = longint'($urandom_range(0, 3));
      endcase
      nxt = $urandom_range(0, 1) ? longint'(fr) + mag : longint'(fr) - mag;
      if ($urandom_range(0, 15) == 0) nxt = longint'(zone_free(total));
      if (nxt < 0) nxt = 0;
      if (nxt > FREE_MAX) nxt = FREE_MAX;
      fr = nxt[31:0];
      if (no_normal && fr >= (total >> 2)) fr = $urandom_range(0, total >> 3);
    end
  endtask

  initial begin
    logic [7:0] stall_set[6];
    logic [7:0] crit_set[6];
    int         sent;
    bit         paused;
    int         len;
    stall_set = '{STALL_RST, 8'd0, 8'd255, 8'd1, 8'd255, 8'd0};
    crit_set  = '{CRIT_RST, 8'd0, 8'd255, 8'd3, 8'd254, 8'd0};
    stall_set[5] = 8'($urandom_range(0, 255));
    crit_set[5]  = 8'($urandom_range(0, 255));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: zones, steps, clamps, stop/start and ignored ops
    push_item(OP_UNUSED, 32'h1000_0000, 32'h10, 8'd50, 1'b1);
    sample(32'd0, 32'h100, 8'd50, 1'b1);
    sample(32'h1000_0000, 32'h0080_0000, 8'd50, 1'b1);
    sample(32'h1000_0000, 32'h0080_0000, 8'd50, 1'b1);
    sample(32'h1000_0000, 32'h0000_0000, 8'd50, 1'b1);
    sample(32'h1000_0000, 32'h0100_0000, 8'd50, 1'b0);
    sample(32'h1000_0000, 32'h0180_0000, 8'd50, 1'b1);
    sample(32'h1000_0000, 32'h0100_0001, 8'd50, 1'b1);
    sample(32'h1000_0000, 32'h0300_0000, 8'd255, 1'b1);
    sample(32'h1000_0000, 32'h0800_0000, 8'd100, 1'b1);
    sample(32'h1000_0000, 32'h0800_0000, 8'd0, 1'b0);
    sample(32'h1000_0000, 32'h0200_0000, 8'd1, 1'b0);
    sample(32'h1000_0000, 32'h0100_0001, 8'd3, 1'b1);
    sample(32'h1000_0000, 32'h0000_0010, 8'd0, 1'b1);
    push_item(OP_STOP, 32'h0, 32'h0, 8'd20, 1'b1);
    push_item(OP_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd20, 1'b0);
    sample(32'h1000_0000, 32'h0000_0010, 8'd20, 1'b1);
    push_item(OP_START, 32'h1000_0000, 32'h10, 8'd20, 1'b0);
    push_item(OP_START, 32'h1000_0000, 32'h10, 8'd20, 1'b1);
    sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd100, 1'b1);
    sample(32'hFFFF_FFFF, 32'h0000_0000, 8'd100, 1'b1);
    sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd100, 1'b0);
    sample(32'd1, 32'd0, 8'd100, 1'b1);
    sample(32'd1, 32'd0, 8'd7, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      load_limits(stall_set[ph], crit_set[ph]);
      idle_on = (ph != 2);
      sent    = 0;
      paused  = 1'b0;
      while (sent < 110) begin
        if ($urandom_range(0, 9) == 0) begin
          push_item(2'($urandom_range(0, 3)), ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom,
                    $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = $urandom_range(3, 16);
          run_walk(len, 1'b0);
          sent += len + 1;
        end
        if (!paused && sent > 55) begin
          drain();
          paused = 1'b1;
        end
      end
      // long stretch outside the normal zone drives the stall count into saturation
      if (ph == 4) run_walk(270, 1'b1);
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/swpr_pkg.sv
src/swpr_eval.sv
src/swap_pressure_swappiness_regulator.sv
src/swpr_checker.sv
tb/swpr_result_checker.sv
tb/tb_swap_pressure_swappiness_regulator.sv
